>>> rtl/icdt_pkg.sv
// Shared types, constants and the month table for the date-time to epoch block.
package icdt_pkg;

  localparam int unsigned YEAR_W = 14;
  localparam int unsigned FIELD_W = 7;
  localparam int unsigned POS_W = 5;
  localparam int unsigned TOD_W = 19;

  localparam logic [POS_W-1:0] POS_YEAR = 5'd0;
  localparam logic [POS_W-1:0] POS_MONTH = 5'd4;
  localparam logic [POS_W-1:0] POS_DAY = 5'd6;
  localparam logic [POS_W-1:0] POS_MARK = 5'd8;
  localparam logic [POS_W-1:0] POS_HOUR = 5'd9;
  localparam logic [POS_W-1:0] POS_MINUTE = 5'd11;
  localparam logic [POS_W-1:0] POS_SECOND = 5'd13;
  localparam logic [POS_W-1:0] POS_ZULU = 5'd15;
  localparam logic [POS_W-1:0] POS_LIMIT = 5'd16;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CHAR_T = 8'h54;

  localparam logic [YEAR_W-1:0] EPOCH_YEAR = 14'd1970;
  localparam logic [31:0] LEAPS_BEFORE_EPOCH = 32'd477;
  localparam logic [31:0] DAYS_PER_YEAR = 32'd365;
  localparam logic [31:0] SECS_PER_DAY = 32'd86400;
  localparam logic [TOD_W-1:0] SECS_PER_HOUR = 19'd3600;
  localparam logic [TOD_W-1:0] SECS_PER_MINUTE = 19'd60;
  localparam logic [3:0] MONTH_MAX = 4'd13;
  localparam logic [3:0] MONTH_MARCH = 4'd3;

  // floor(q / 25) == (q * DIV25_MULT) >> 20 for q below 2^15
  localparam logic [27:0] DIV25_MULT = 28'd41944;
  localparam logic [11:0] DIV25 = 12'd25;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [FIELD_W-1:0] month;
    logic [FIELD_W-1:0] day;
    logic [FIELD_W-1:0] hour;
    logic [FIELD_W-1:0] minute;
    logic [FIELD_W-1:0] second;
    logic               too_short;
    logic               use_time;
  } job_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [6:0]         q_year;
    logic [6:0]         q_prev;
    logic [4:0]         q_prev400;
    logic [11:0]        prev_q4;
    logic [YEAR_W-1:0]  year_off;
    logic               after_epoch;
    logic [FIELD_W-1:0] month;
    logic [FIELD_W-1:0] day;
    logic [FIELD_W-1:0] hour;
    logic [FIELD_W-1:0] minute;
    logic [FIELD_W-1:0] second;
    logic               too_short;
    logic               use_time;
  } yr_t;

  typedef struct packed {
    logic [31:0]      days;
    logic [TOD_W-1:0] tod;
    logic             too_short;
  } day_t;

  function automatic logic [8:0] days_before_month(input logic [3:0] m);
    logic [8:0] d;
    case (m)
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      4'd13:   d = 9'd365;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

>>> rtl/ical_datetime_to_epoch.sv
// iCalendar date or date-time characters in, Unix seconds out.
// Throughput: one character word per cycle while in_stall is low, results included.
// Path: the edge that takes the last character loads the job register; the job then passes
//   the year stage, day-sum stage and seconds register before the result word is valid.
// Stalls on the output hold the pipeline and back up to in_stall without loss.
// Reset (rst_n low, synchronous) clears position, partial fields and all valids.
module ical_datetime_to_epoch import icdt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_character,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_epoch_seconds
);

  logic job_valid;
  logic job_ready;
  job_t job;

  icdt_field_acc u_acc (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_character (in_character),
    .in_last      (in_last),
    .in_stall     (in_stall),
    .job_ready    (job_ready),
    .job_valid    (job_valid),
    .job          (job)
  );

  icdt_epoch_calc u_calc (
    .clk               (clk),
    .rst_n             (rst_n),
    .job_valid         (job_valid),
    .job               (job),
    .job_ready         (job_ready),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_epoch_seconds (out_epoch_seconds)
  );

endmodule

>>> rtl/icdt_field_acc.sv
// Character parser: positional decimal field accumulation and job register.
module icdt_field_acc import icdt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] in_character,
  input  logic       in_last,
  output logic       in_stall,
  input  logic       job_ready,
  output logic       job_valid,
  output job_t       job
);

  typedef enum logic [2:0] {
    SEL_NONE, SEL_YEAR, SEL_MONTH, SEL_DAY, SEL_MARK, SEL_HOUR, SEL_MINUTE, SEL_SECOND
  } sel_t;

  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [YEAR_W-1:0]  year_r, year_nxt;
  logic [FIELD_W-1:0] month_r, month_nxt, day_r, day_nxt;
  logic [FIELD_W-1:0] hour_r, hour_nxt, minute_r, minute_nxt, second_r, second_nxt;
  logic               stop_r, stop_nxt, tmark_r, tmark_nxt;
  logic               job_v_r;
  job_t               job_r, job_nxt;

  sel_t               sel;
  logic               first;
  logic               is_dig;
  logic [3:0]         dv;
  logic [YEAR_W-1:0]  cur, val;
  logic               accept;

  assign in_stall  = job_v_r && !job_ready;
  assign accept    = in_valid && !in_stall;
  assign job_valid = job_v_r;
  assign job       = job_r;

  always_comb begin
    pos_nxt = (pos_r < POS_LIMIT) ? pos_r + 5'd1 : pos_r;
    sel   = SEL_NONE;
    first = 1'b0;
    if (pos_r < POS_MONTH) begin
      sel = SEL_YEAR;
      first = (pos_r == POS_YEAR);
    end else if (pos_r < POS_DAY) begin
      sel = SEL_MONTH;
      first = (pos_r == POS_MONTH);
    end else if (pos_r < POS_MARK) begin
      sel = SEL_DAY;
      first = (pos_r == POS_DAY);
    end else if (pos_r == POS_MARK) begin
      sel = SEL_MARK;
    end else if (pos_r < POS_MINUTE) begin
      sel = SEL_HOUR;
      first = (pos_r == POS_HOUR);
    end else if (pos_r < POS_SECOND) begin
      sel = SEL_MINUTE;
      first = (pos_r == POS_MINUTE);
    end else if (pos_r < POS_ZULU) begin
      sel = SEL_SECOND;
      first = (pos_r == POS_SECOND);
    end

    case (sel)
      SEL_YEAR:   cur = year_r;
      SEL_MONTH:  cur = YEAR_W'(month_r);
      SEL_DAY:    cur = YEAR_W'(day_r);
      SEL_HOUR:   cur = YEAR_W'(hour_r);
      SEL_MINUTE: cur = YEAR_W'(minute_r);
      SEL_SECOND: cur = YEAR_W'(second_r);
      default:    cur = '0;
    endcase

    is_dig = (in_character >= CHAR_ZERO) && (in_character <= CHAR_NINE);
    dv     = 4'(in_character - CHAR_ZERO);

    // atoi: stop at the first non-digit of the field
    if (first) begin
      stop_nxt = !is_dig;
      val = is_dig ? YEAR_W'(dv) : '0;
    end else if (!stop_r && is_dig) begin
      stop_nxt = stop_r;
      val = 14'(cur * 14'd10) + YEAR_W'(dv);
    end else begin
      stop_nxt = 1'b1;
      val = cur;
    end

    year_nxt   = year_r;
    month_nxt  = month_r;
    day_nxt    = day_r;
    hour_nxt   = hour_r;
    minute_nxt = minute_r;
    second_nxt = second_r;
    tmark_nxt  = tmark_r;
    case (sel)
      SEL_YEAR:   year_nxt = val;
      SEL_MONTH:  month_nxt = val[FIELD_W-1:0];
      SEL_DAY:    day_nxt = val[FIELD_W-1:0];
      SEL_HOUR:   hour_nxt = val[FIELD_W-1:0];
      SEL_MINUTE: minute_nxt = val[FIELD_W-1:0];
      SEL_SECOND: second_nxt = val[FIELD_W-1:0];
      default:    ;
    endcase
    if (sel == SEL_MARK) begin
      tmark_nxt = (in_character == CHAR_T);
      stop_nxt  = stop_r;
    end else if (sel == SEL_NONE) begin
      stop_nxt = stop_r;
    end

    job_nxt.year      = year_nxt;
    job_nxt.month     = month_nxt;
    job_nxt.day       = day_nxt;
    job_nxt.hour      = hour_nxt;
    job_nxt.minute    = minute_nxt;
    job_nxt.second    = second_nxt;
    job_nxt.too_short = (pos_nxt < POS_MARK);
    job_nxt.use_time  = (pos_nxt == POS_LIMIT) && tmark_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      year_r   <= '0;
      month_r  <= '0;
      day_r    <= '0;
      hour_r   <= '0;
      minute_r <= '0;
      second_r <= '0;
      stop_r   <= 1'b0;
      tmark_r  <= 1'b0;
      job_v_r  <= 1'b0;
    end else begin
      if (accept && in_last) begin
        pos_r    <= '0;
        year_r   <= '0;
        month_r  <= '0;
        day_r    <= '0;
        hour_r   <= '0;
        minute_r <= '0;
        second_r <= '0;
        stop_r   <= 1'b0;
        tmark_r  <= 1'b0;
      end else if (accept) begin
        pos_r    <= pos_nxt;
        year_r   <= year_nxt;
        month_r  <= month_nxt;
        day_r    <= day_nxt;
        hour_r   <= hour_nxt;
        minute_r <= minute_nxt;
        second_r <= second_nxt;
        stop_r   <= stop_nxt;
        tmark_r  <= tmark_nxt;
      end
      if (accept && in_last) begin
        job_v_r <= 1'b1;
      end else if (job_ready) begin
        job_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_last) begin
      job_r <= job_nxt;
    end
  end

  a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_last) |=> (pos_r == '0 && year_r == '0 && !tmark_r))
    else $error("parser state not cleared after last word");

  a_pos_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !in_last && pos_r < POS_LIMIT) |=> (pos_r == $past(pos_r) + 5'd1))
    else $error("character position did not advance");

  a_job_held: assert property (@(posedge clk) disable iff (!rst_n)
    (job_v_r && !job_ready) |=> (job_v_r && job_r == $past(job_r)))
    else $error("pending job lost while downstream busy");

endmodule

>>> rtl/icdt_epoch_calc.sv
// Three-stage epoch arithmetic: year division, day and time-of-day sum, seconds scale.
module icdt_epoch_calc import icdt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        job_valid,
  input  job_t        job,
  output logic        job_ready,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_epoch_seconds
);

  logic        b_v_r, c_v_r, out_valid_r;
  yr_t         b_r, b_nxt;
  day_t        c_r, c_nxt;
  logic [31:0] out_r, out_nxt;
  logic        free_b, free_c, free_d;

  logic [YEAR_W-1:0] prev;
  logic [27:0]       prod_y, prod_p, prod_p400;

  logic              div4, rem_zero, div100, leap;
  logic [3:0]        mc;
  logic [31:0]       leaps, dby, md;

  assign free_d    = !out_valid_r || !out_stall;
  assign free_c    = !c_v_r || free_d;
  assign free_b    = !b_v_r || free_c;
  assign job_ready = free_b;
  assign out_valid = out_valid_r;
  assign out_epoch_seconds = out_r;

  always_comb begin
    prev      = job.year - 14'd1;
    prod_y    = 28'(job.year[YEAR_W-1:2]) * DIV25_MULT;
    prod_p    = 28'(prev[YEAR_W-1:2]) * DIV25_MULT;
    prod_p400 = 28'(prev[YEAR_W-1:4]) * DIV25_MULT;

    b_nxt.year        = job.year;
    b_nxt.q_year      = prod_y[26:20];
    b_nxt.q_prev      = prod_p[26:20];
    b_nxt.q_prev400   = prod_p400[24:20];
    b_nxt.prev_q4     = prev[YEAR_W-1:2];
    b_nxt.year_off    = job.year - EPOCH_YEAR;
    b_nxt.after_epoch = (job.year > EPOCH_YEAR);
    b_nxt.month       = job.month;
    b_nxt.day         = job.day;
    b_nxt.hour        = job.hour;
    b_nxt.minute      = job.minute;
    b_nxt.second      = job.second;
    b_nxt.too_short   = job.too_short;
    b_nxt.use_time    = job.use_time;
  end

  always_comb begin
    div4     = (b_r.year[1:0] == 2'd0);
    rem_zero = (b_r.year[YEAR_W-1:2] == 12'(12'(b_r.q_year) * DIV25));
    div100   = div4 && rem_zero;
    leap     = div4 && (!div100 || (b_r.q_year[1:0] == 2'd0));

    leaps = 32'(b_r.prev_q4) - 32'(b_r.q_prev) + 32'(b_r.q_prev400);
    dby   = b_r.after_epoch
          ? 32'(32'(b_r.year_off) * DAYS_PER_YEAR) + leaps - LEAPS_BEFORE_EPOCH
          : 32'd0;

    mc = (b_r.month > 7'(MONTH_MAX)) ? MONTH_MAX : b_r.month[3:0];
    md = 32'(days_before_month(mc)) + 32'((mc >= MONTH_MARCH) && leap);

    c_nxt.days      = dby + md + 32'(b_r.day) - 32'd1;
    c_nxt.tod       = b_r.use_time
                    ? TOD_W'(TOD_W'(b_r.hour) * SECS_PER_HOUR)
                      + TOD_W'(TOD_W'(b_r.minute) * SECS_PER_MINUTE)
                      + TOD_W'(b_r.second)
                    : '0;
    c_nxt.too_short = b_r.too_short;
  end

  always_comb begin
    out_nxt = c_r.too_short ? 32'd0 : 32'(c_r.days * SECS_PER_DAY) + 32'(c_r.tod);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r       <= 1'b0;
      c_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (free_b) begin
        b_v_r <= job_valid;
      end
      if (free_c) begin
        c_v_r <= b_v_r;
      end
      if (free_d) begin
        out_valid_r <= c_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (free_b && job_valid) begin
      b_r <= b_nxt;
    end
    if (free_c && b_v_r) begin
      c_r <= c_nxt;
    end
    if (free_d && c_v_r) begin
      out_r <= out_nxt;
    end
  end

  a_c_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (c_v_r && free_d) |=> out_valid_r)
    else $error("result stage dropped a word");

  a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (c_v_r && free_d && c_r.too_short) |=> (out_r == 32'd0))
    else $error("short value gave nonzero seconds");

  a_b_held: assert property (@(posedge clk) disable iff (!rst_n)
    (b_v_r && !free_c) |=> (b_v_r && b_r == $past(b_r)))
    else $error("year stage changed while blocked");

endmodule
